// ----- hdl/svac_pkg.sv -----
// Shared types and register indexes for the strided view address unit.
`timescale 1ns / 1ps

package svac_pkg;

    localparam int COORD_W = 16;
    localparam int LIN_W   = 32;
    localparam int CFG_W   = 32;
    localparam int OUT_W   = 32;

    // configuration register indexes
    localparam logic [2:0] REG_VIEW_DIMS   = 3'd0;
    localparam logic [2:0] REG_IS_VIEW     = 3'd1;
    localparam logic [2:0] REG_EXTENT_1    = 3'd2;
    localparam logic [2:0] REG_EXTENT_2    = 3'd3;
    localparam logic [2:0] REG_STRIDE_0    = 3'd4;
    localparam logic [2:0] REG_STRIDE_1    = 3'd5;
    localparam logic [2:0] REG_STRIDE_2    = 3'd6;
    localparam logic [2:0] REG_BASE_OFFSET = 3'd7;

    localparam logic KIND_LINEAR = 1'b0;
    localparam logic KIND_COORD  = 1'b1;

    typedef struct packed {
        logic [1:0] dims;
        logic       is_view;
    } svac_ctl_t;

    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] c0;
        logic [COORD_W-1:0] c1;
        logic [COORD_W-1:0] c2;
    } svac_side_t;

    typedef struct packed {
        svac_side_t         side;
        logic [COORD_W-1:0] r1;
    } svac_side2_t;

endpackage

// ----- hdl/strided_view_address_calc_unit.sv -----
// Top level of the strided view address unit: config registers and pipeline.
`timescale 1ns / 1ps

// Turns a linear view index (kind 0) or explicit coordinates (kind 1) into a
// physical element address: base_offset plus each coordinate times its
// stride, wrapping at ADDR_WIDTH bits (capped at 32) and zero-extended to the
// 32-bit result. With is_view clear a linear index passes straight through
// plus base_offset. Linear indexes are split by two chained pipelined
// restoring dividers (first by the innermost extent, then by the next one),
// each 32 stages of one quotient bit, followed by three stages of multiply
// and add and the output register: a new word is taken every cycle while
// item_ready is high. A one-word skid stage behind the output register
// keeps the pipeline flowing while the consumer stalls; item_ready drops
// only once that skid word is occupied. Extents of 0 act as 1, view_dims
// of 0 acts as 1 and values above MAX_DIMS saturate. Registers are written
// through cfg_we/cfg_index/cfg_data and must only change while the pipeline
// is empty.
module strided_view_address_calc_unit
    import svac_pkg::*;
#(
    parameter int MAX_DIMS   = 3,
    parameter int ADDR_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               item_valid,
    output logic               item_ready,
    input  logic               kind,
    input  logic [LIN_W-1:0]   linear_index,
    input  logic [COORD_W-1:0] coord_0,
    input  logic [COORD_W-1:0] coord_1,
    input  logic [COORD_W-1:0] coord_2,
    output logic               addr_valid,
    input  logic               addr_ready,
    output logic [OUT_W-1:0]   element_address
);

    localparam int AW_EFF = (ADDR_WIDTH < OUT_W) ? ADDR_WIDTH : OUT_W;

    // configuration registers
    logic [1:0]         view_dims_reg;
    logic               is_view_reg;
    logic [COORD_W-1:0] extent_1_reg, extent_2_reg;
    logic [CFG_W-1:0]   stride_0_reg, stride_1_reg, stride_2_reg, base_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            view_dims_reg   <= 2'd1;
            is_view_reg     <= 1'b0;
            extent_1_reg    <= 16'd1;
            extent_2_reg    <= 16'd1;
            stride_0_reg    <= 32'd1;
            stride_1_reg    <= 32'd1;
            stride_2_reg    <= 32'd1;
            base_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_VIEW_DIMS:   view_dims_reg   <= cfg_data[1:0];
                REG_IS_VIEW:     is_view_reg     <= cfg_data[0];
                REG_EXTENT_1:    extent_1_reg    <= cfg_data[COORD_W-1:0];
                REG_EXTENT_2:    extent_2_reg    <= cfg_data[COORD_W-1:0];
                REG_STRIDE_0:    stride_0_reg    <= cfg_data;
                REG_STRIDE_1:    stride_1_reg    <= cfg_data;
                REG_STRIDE_2:    stride_2_reg    <= cfg_data;
                REG_BASE_OFFSET: base_offset_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // effective dims, divisors; user holds static while words are in flight
    svac_ctl_t          ctl;
    logic [1:0]         dims_raw;
    logic [COORD_W-1:0] ext1, ext2, div_a, div_b;

    always_comb
    begin
        dims_raw = (view_dims_reg == 2'd0) ? 2'd1 : view_dims_reg;
        ctl.dims = (32'(dims_raw) > MAX_DIMS) ? 2'(MAX_DIMS) : dims_raw;
        ctl.is_view = is_view_reg;
        ext1 = (extent_1_reg == '0) ? 16'd1 : extent_1_reg;
        ext2 = (extent_2_reg == '0) ? 16'd1 : extent_2_reg;
        // first split peels off the innermost dim, second splits dims 0/1
        if (!is_view_reg || ctl.dims == 2'd1)
            div_a = 16'd1;
        else if (ctl.dims == 2'd3)
            div_a = ext2;
        else
            div_a = ext1;
        div_b = (is_view_reg && ctl.dims == 2'd3) ? ext1 : 16'd1;
    end

    // global advance: whole pipeline moves unless the skid word is held
    logic en;
    assign item_ready = en;

    svac_side_t  side_in, side_a;
    svac_side2_t side2_in, side_b;
    logic               v_a, v_b;
    logic [LIN_W-1:0]   q_a, q_b;
    logic [COORD_W-1:0] r_a, r_b;

    assign side_in = '{kind: kind, c0: coord_0, c1: coord_1, c2: coord_2};

    svac_divider #(.DW(LIN_W), .VW(COORD_W), .SW($bits(svac_side_t))) u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (item_valid),
        .dividend  (linear_index),
        .divisor   (div_a),
        .side_in   (side_in),
        .out_valid (v_a),
        .quotient  (q_a),
        .remainder (r_a),
        .side_out  (side_a)
    );

    assign side2_in = '{side: side_a, r1: r_a};

    svac_divider #(.DW(LIN_W), .VW(COORD_W), .SW($bits(svac_side2_t))) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v_a),
        .dividend  (q_a),
        .divisor   (div_b),
        .side_in   (side2_in),
        .out_valid (v_b),
        .quotient  (q_b),
        .remainder (r_b),
        .side_out  (side_b)
    );

    logic             v_w;
    logic [OUT_W-1:0] addr_w;

    svac_weight #(.AW(AW_EFF)) u_weight (
        .clk         (clk),
        .rst_n       (rst_n),
        .en          (en),
        .in_valid    (v_b),
        .ctl         (ctl),
        .side        (side_b.side),
        .q2          (q_b),
        .r2          (r_b),
        .r1          (side_b.r1),
        .stride_0    (stride_0_reg),
        .stride_1    (stride_1_reg),
        .stride_2    (stride_2_reg),
        .base_offset (base_offset_reg),
        .out_valid   (v_w),
        .addr        (addr_w)
    );

    svac_skid #(.W(OUT_W)) u_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (v_w),
        .up_data   (addr_w),
        .up_ready  (en),
        .out_valid (addr_valid),
        .out_ready (addr_ready),
        .out_data  (element_address)
    );

    // a stall upstream only ever comes from a held output word
    a_stall_needs_output: assert property (@(posedge clk) disable iff (!rst_n)
        !item_ready |-> addr_valid)
        else $error("pipeline stalled without a pending output word");

    // the skid fills only when the output was held in the previous cycle
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(item_ready) |-> $past(addr_valid && !addr_ready))
        else $error("skid stage filled while output was free");

    // a taken output with a full skid refills the output at once
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (!item_ready && addr_ready) |=> (addr_valid && item_ready))
        else $error("skid word lost or not drained");

endmodule

// ----- hdl/svac_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, with sideband payload.
`timescale 1ns / 1ps

module svac_divider #(
    parameter int DW = 32,
    parameter int VW = 16,
    parameter int SW = 1
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          in_valid,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    input  logic [SW-1:0] side_in,
    output logic          out_valid,
    output logic [DW-1:0] quotient,
    output logic [VW-1:0] remainder,
    output logic [SW-1:0] side_out
);

    logic [DW-1:0] vld_reg;
    logic [DW-1:0] dvd_reg  [0:DW-1];
    logic [VW-1:0] rem_reg  [0:DW-1];
    logic [SW-1:0] side_reg [0:DW-1];

    logic          stg_vld  [0:DW];
    logic [DW-1:0] stg_dvd  [0:DW];
    logic [VW-1:0] stg_rem  [0:DW];
    logic [SW-1:0] stg_side [0:DW];

    assign stg_vld[0]  = in_valid;
    assign stg_dvd[0]  = dividend;
    assign stg_rem[0]  = '0;
    assign stg_side[0] = side_in;

    genvar i;
    generate
        for (i = 0; i < DW; i++)
        begin : g_stage
            logic [VW:0] trial;
            logic [VW:0] diff;
            logic        ge;

            assign trial = {stg_rem[i], stg_dvd[i][DW-1]};
            assign ge    = trial >= {1'b0, divisor};
            assign diff  = trial - {1'b0, divisor};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[i] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[i] <= stg_vld[i];
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dvd_reg[i]  <= {stg_dvd[i][DW-2:0], ge};
                    rem_reg[i]  <= ge ? diff[VW-1:0] : trial[VW-1:0];
                    side_reg[i] <= stg_side[i];
                end
            end

            assign stg_vld[i+1]  = vld_reg[i];
            assign stg_dvd[i+1]  = dvd_reg[i];
            assign stg_rem[i+1]  = rem_reg[i];
            assign stg_side[i+1] = side_reg[i];
        end
    endgenerate

    assign out_valid = stg_vld[DW];
    assign quotient  = stg_dvd[DW];
    assign remainder = stg_rem[DW];
    assign side_out  = stg_side[DW];

endmodule

// ----- hdl/svac_weight.sv -----
// Coordinate select, stride weighting and base add, three register stages.
`timescale 1ns / 1ps

module svac_weight
    import svac_pkg::*;
#(
    parameter int AW = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  svac_ctl_t          ctl,
    input  svac_side_t         side,
    input  logic [LIN_W-1:0]   q2,
    input  logic [COORD_W-1:0] r2,
    input  logic [COORD_W-1:0] r1,
    input  logic [CFG_W-1:0]   stride_0,
    input  logic [CFG_W-1:0]   stride_1,
    input  logic [CFG_W-1:0]   stride_2,
    input  logic [CFG_W-1:0]   base_offset,
    output logic               out_valid,
    output logic [OUT_W-1:0]   addr
);

    logic [2:0]         vld_reg;
    logic [AW-1:0]      p0_reg, p1_reg, p2_reg;
    logic [AW-1:0]      p0_next, p1_next, p2_next;
    logic [AW-1:0]      s01_reg, s2b_reg, sum_reg;
    logic [LIN_W-1:0]   c0;
    logic [COORD_W-1:0] c1, c2;
    logic               pass;
    logic               use1, use2;

    always_comb
    begin
        pass = (side.kind == KIND_LINEAR) && !ctl.is_view;
        use1 = !pass && (ctl.dims >= 2'd2);
        use2 = !pass && (ctl.dims == 2'd3);
        if (side.kind == KIND_COORD)
        begin
            c0 = LIN_W'(side.c0);
            c1 = side.c1;
            c2 = side.c2;
        end
        else
        begin
            // outer quotient is dim 0; inner remainder is the innermost dim
            c0 = q2;
            c1 = (ctl.dims == 2'd3) ? r2 : r1;
            c2 = r1;
        end
        p0_next = pass ? c0[AW-1:0] : c0[AW-1:0] * stride_0[AW-1:0];
        p1_next = use1 ? AW'(c1) * stride_1[AW-1:0] : '0;
        p2_next = use2 ? AW'(c2) * stride_2[AW-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_reg  <= p0_next;
            p1_reg  <= p1_next;
            p2_reg  <= p2_next;
            s01_reg <= p0_reg + p1_reg;
            s2b_reg <= p2_reg + base_offset[AW-1:0];
            sum_reg <= s01_reg + s2b_reg;
        end
    end

    assign out_valid = vld_reg[2];
    assign addr      = OUT_W'(sum_reg);

endmodule

// ----- hdl/svac_skid.sv -----
// Output register with a one-word skid stage.
`timescale 1ns / 1ps

module svac_skid #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         up_valid,
    input  logic [W-1:0] up_data,
    output logic         up_ready,
    output logic         out_valid,
    input  logic         out_ready,
    output logic [W-1:0] out_data
);

    logic         out_v_reg, out_v_next;
    logic         skid_v_reg, skid_v_next;
    logic [W-1:0] out_d_reg, out_d_next;
    logic [W-1:0] skid_d_reg, skid_d_next;

    assign up_ready = !skid_v_reg;

    always_comb
    begin
        out_v_next  = out_v_reg;
        skid_v_next = skid_v_reg;
        out_d_next  = out_d_reg;
        skid_d_next = skid_d_reg;
        if (!out_v_reg || out_ready)
        begin
            if (skid_v_reg)
            begin
                out_d_next  = skid_d_reg;
                out_v_next  = 1'b1;
                skid_v_next = 1'b0;
            end
            else
            begin
                out_d_next = up_data;
                out_v_next = up_valid;
            end
        end
        else if (up_valid && !skid_v_reg)
        begin
            skid_d_next = up_data;
            skid_v_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else
        begin
            out_v_reg  <= out_v_next;
            skid_v_reg <= skid_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_d_reg  <= out_d_next;
        skid_d_reg <= skid_d_next;
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_d_reg;

endmodule

// ----- sim/strided_view_address_calc_unit_test.sv -----
// Self-checking testbench for the strided view address unit.
`timescale 1ns / 1ps

module strided_view_address_calc_unit_test;
    import svac_pkg::*;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               item_valid;
    logic               item_ready;
    logic               kind;
    logic [LIN_W-1:0]   linear_index;
    logic [COORD_W-1:0] coord_0;
    logic [COORD_W-1:0] coord_1;
    logic [COORD_W-1:0] coord_2;
    logic               addr_valid;
    logic               addr_ready;
    logic [OUT_W-1:0]   element_address;

    strided_view_address_calc_unit dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .item_valid(item_valid), .item_ready(item_ready),
        .kind(kind), .linear_index(linear_index),
        .coord_0(coord_0), .coord_1(coord_1), .coord_2(coord_2),
        .addr_valid(addr_valid), .addr_ready(addr_ready),
        .element_address(element_address)
    );

    // shadow copy of the configuration registers
    logic [1:0]  sh_dims;
    logic        sh_view;
    logic [15:0] sh_ext1, sh_ext2;
    logic [31:0] sh_str0, sh_str1, sh_str2, sh_base;

    logic [31:0] addr_q[$];   // expected addresses, oldest first
    int          mismatches;

    typedef struct {
        logic        k;
        logic [31:0] lin;
        logic [15:0] c0, c1, c2;
        bit          has_exp;  // expected typed in by hand
        logic [31:0] exp;
    } row_t;

    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop: ~1650 words plus the worst random gaps and stalls
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

    // address predictor: split linear index by child steps, weight by strides
    function automatic logic [31:0] calc_address(logic k, logic [31:0] lin,
                                                 logic [15:0] c0, logic [15:0] c1,
                                                 logic [15:0] c2);
        int unsigned n;
        logic [63:0] e1, e2, step0, step1, rem;
        logic [63:0] co[3];
        logic [31:0] a;
        n = (sh_dims == 2'd0) ? 32'd1 : 32'(sh_dims);
        e1 = (sh_ext1 == 16'd0) ? 64'd1 : {48'd0, sh_ext1};
        e2 = (sh_ext2 == 16'd0) ? 64'd1 : {48'd0, sh_ext2};
        if (k == KIND_LINEAR && !sh_view)
            return lin + sh_base;
        if (k == KIND_LINEAR) begin
            co[0] = 64'd0; co[1] = 64'd0; co[2] = 64'd0;
            if (n == 1) begin
                co[0] = 64'(lin);
            end else if (n == 2) begin
                co[0] = 64'(lin) / e1;
                co[1] = 64'(lin) % e1;
            end else begin
                step1 = e2;
                step0 = e1 * e2;
                co[0] = 64'(lin) / step0;
                rem   = 64'(lin) % step0;
                co[1] = rem / step1;
                co[2] = rem % step1;
            end
        end else begin
            co[0] = 64'(c0); co[1] = 64'(c1); co[2] = 64'(c2);
        end
        a = co[0][31:0] * sh_str0;
        if (n > 1) a = a + co[1][31:0] * sh_str1;
        if (n > 2) a = a + co[2][31:0] * sh_str2;
        return a + sh_base;
    endfunction

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_VIEW_DIMS:   sh_dims = val[1:0];
            REG_IS_VIEW:     sh_view = val[0];
            REG_EXTENT_1:    sh_ext1 = val[15:0];
            REG_EXTENT_2:    sh_ext2 = val[15:0];
            REG_STRIDE_0:    sh_str0 = val;
            REG_STRIDE_1:    sh_str1 = val;
            REG_STRIDE_2:    sh_str2 = val;
            default:         sh_base = val;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_config(logic [1:0] d, logic v, logic [15:0] e1, logic [15:0] e2,
                              logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
                              logic [31:0] b);
        write_reg(REG_VIEW_DIMS, 32'(d));
        write_reg(REG_IS_VIEW, 32'(v));
        write_reg(REG_EXTENT_1, 32'(e1));
        write_reg(REG_EXTENT_2, 32'(e2));
        write_reg(REG_STRIDE_0, s0);
        write_reg(REG_STRIDE_1, s1);
        write_reg(REG_STRIDE_2, s2);
        write_reg(REG_BASE_OFFSET, b);
    endtask

    // one word: random gap, hold valid until taken, queue expected address
    task automatic send_word(logic k, logic [31:0] lin, logic [15:0] c0,
                             logic [15:0] c1, logic [15:0] c2,
                             bit has_exp, logic [31:0] exp);
        int gap;
        gap = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        kind         <= k;
        linear_index <= lin;
        coord_0      <= c0;
        coord_1      <= c1;
        coord_2      <= c2;
        addr_q.push_back(has_exp ? exp : calc_address(k, lin, c0, c1, c2));
        do @(posedge clk); while (!item_ready);
    endtask

    // drain all outstanding words, then let the pipeline settle
    task automatic wait_idle();
        item_valid <= 1'b0;
        while (addr_q.size() != 0) @(posedge clk);
        repeat (80) @(posedge clk);
    endtask

    // consumer side: random stalls drawn per word
    initial begin
        int stall;
        addr_ready = 1'b0;
        @(posedge rst_n);
        forever begin
            stall = (($urandom & 3) == 0) ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                addr_ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            addr_ready <= 1'b1;
            do @(posedge clk); while (!addr_valid);
        end
    end

    // output checker, samples at the accepting edge
    always @(posedge clk) begin
        if (rst_n && addr_valid && addr_ready) begin
            if (addr_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected word: element_address=%h", element_address);
            end else begin
                logic [31:0] e;
                e = addr_q.pop_front();
                if (e !== element_address) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("element_address mismatch: expected %h got %h",
                                 e, element_address);
                end
            end
        end
    end

    initial begin
        row_t rows[$];
        int   total;
        logic [31:0] lin;
        mismatches = 0;
        rst_n = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
        item_valid = 1'b0; kind = KIND_LINEAR; linear_index = '0;
        coord_0 = '0; coord_1 = '0; coord_2 = '0;
        sh_dims = 2'd1; sh_view = 1'b0; sh_ext1 = 16'd1; sh_ext2 = 16'd1;
        sh_str0 = 32'd1; sh_str1 = 32'd1; sh_str2 = 32'd1; sh_base = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        // directed table, reset config: pass-through, coordinates use dim 0 only
        rows = '{
            '{KIND_LINEAR, 32'h0,        16'h0,    16'h0,    16'h0,    1, 32'h0},
            '{KIND_LINEAR, 32'hFFFFFFFF, 16'h0,    16'h0,    16'h0,    1, 32'hFFFFFFFF},
            '{KIND_LINEAR, 32'h12345678, 16'h0,    16'h0,    16'h0,    1, 32'h12345678},
            '{KIND_COORD,  32'h0,        16'hFFFF, 16'hFFFF, 16'hFFFF, 1, 32'h0000FFFF},
            '{KIND_COORD,  32'hFFFFFFFF, 16'h0,    16'h5555, 16'hAAAA, 1, 32'h0}
        };
        foreach (rows[i])
            send_word(rows[i].k, rows[i].lin, rows[i].c0, rows[i].c1, rows[i].c2,
                      rows[i].has_exp, rows[i].exp);
        wait_idle();

        // 3-D view, max extents and strides; oversized index wraps dim 0
        set_config(2'd3, 1'b1, 16'hFFFF, 16'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF,
                   32'hFFFFFFFF, 32'hFFFFFFFF);
        rows = '{
            '{KIND_LINEAR, 32'h0,        16'h0,    16'h0,    16'h0,    1, 32'hFFFFFFFF},
            '{KIND_LINEAR, 32'hFFFFFFFF, 16'h0,    16'h0,    16'h0,    0, 32'h0},
            '{KIND_LINEAR, 32'h0000FFFF, 16'h0,    16'h0,    16'h0,    0, 32'h0},
            '{KIND_COORD,  32'h0,        16'hFFFF, 16'hFFFF, 16'hFFFF, 0, 32'h0},
            '{KIND_COORD,  32'h0,        16'h0,    16'h0,    16'h0,    1, 32'hFFFFFFFF}
        };
        foreach (rows[i])
            send_word(rows[i].k, rows[i].lin, rows[i].c0, rows[i].c1, rows[i].c2,
                      rows[i].has_exp, rows[i].exp);
        wait_idle();

        // zero dims acts as one, zero extents act as one, zero strides
        set_config(2'd0, 1'b1, 16'h0, 16'h0, 32'h0, 32'h0, 32'h0, 32'h10);
        rows = '{
            '{KIND_LINEAR, 32'hFFFFFFFF, 16'h0,    16'h0,    16'h0,    1, 32'h10},
            '{KIND_COORD,  32'h0,        16'h1234, 16'h1,    16'h2,    1, 32'h10}
        };
        foreach (rows[i])
            send_word(rows[i].k, rows[i].lin, rows[i].c0, rows[i].c1, rows[i].c2,
                      rows[i].has_exp, rows[i].exp);
        wait_idle();

        // 2-D view with small extents; zero extent in the unused dim
        set_config(2'd2, 1'b1, 16'd7, 16'h0, 32'd100, 32'd3, 32'd9, 32'h0);
        rows = '{
            '{KIND_LINEAR, 32'd6,  16'h0, 16'h0, 16'h0, 0, 32'h0},
            '{KIND_LINEAR, 32'd7,  16'h0, 16'h0, 16'h0, 0, 32'h0},
            '{KIND_LINEAR, 32'd50, 16'h0, 16'h0, 16'h0, 0, 32'h0},
            '{KIND_COORD,  32'h0,  16'd2, 16'd5, 16'hFFFF, 0, 32'h0}
        };
        foreach (rows[i])
            send_word(rows[i].k, rows[i].lin, rows[i].c0, rows[i].c1, rows[i].c2,
                      rows[i].has_exp, rows[i].exp);
        wait_idle();

        // random phases: new random config each phase, mostly small extents
        total = 0;
        while (total < 1650) begin
            logic [15:0] e1, e2;
            e1 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            e2 = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 20));
            set_config(2'($urandom), ($urandom_range(0, 4) != 0), e1, e2,
                       $urandom, $urandom, $urandom,
                       ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom);
            repeat (110) begin
                case ($urandom_range(0, 3))
                    0:       lin = $urandom;
                    1:       lin = $urandom_range(0, 2000);
                    default: lin = $urandom_range(0, 32'(e1) * 32'(e2) * 4 + 4);
                endcase
                send_word(logic'($urandom), lin, 16'($urandom), 16'($urandom),
                          16'($urandom), 0, 32'h0);
            end
            total += 110;
            wait_idle();
        end

        if (mismatches == 0 && addr_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/svac_pkg.sv
hdl/svac_divider.sv
hdl/svac_weight.sv
hdl/svac_skid.sv
hdl/strided_view_address_calc_unit.sv
sim/strided_view_address_calc_unit_test.sv
